/* design/plsu_pkg.sv */
// plsu_pkg: shared constants, register codes and types of the lattice site update
// no dependencies

package plsu_pkg;

  localparam int MAX_HALF_SIZE = 512;

  localparam int PHASE_W    = 32;
  localparam int COORD_W    = 11;
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int HS_W       = 10;
  localparam int INNER_W    = 19;
  localparam int COEF_W     = 16;

  localparam int TERM_W  = 48;
  localparam int LANE_W  = 50;
  localparam int TOTAL_W = 52;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_SIZE   = 3'd0,
    CFG_INNER_R2    = 3'd1,
    CFG_SIN_COEF    = 3'd2,
    CFG_COS_COEF    = 3'd3,
    CFG_SIN2_COEF   = 3'd4,
    CFG_COS2_COEF   = 3'd5,
    CFG_STEP_SIZE   = 3'd6
  } cfg_idx_e;

  localparam logic [HS_W-1:0]    RST_HALF_SIZE = 10'd200;
  localparam logic [INNER_W-1:0] RST_INNER_R2  = 19'd0;
  localparam logic [COEF_W-1:0]  RST_SIN_COEF  = 16'd16384;
  localparam logic [COEF_W-1:0]  RST_COS_COEF  = 16'd6554;
  localparam logic [COEF_W-1:0]  RST_SIN2_COEF = 16'd0;
  localparam logic [COEF_W-1:0]  RST_COS2_COEF = 16'd0;
  localparam logic [COEF_W-1:0]  RST_STEP_SIZE = 16'd13107;

  // quarter turn, also 1.0 in q1.30
  localparam logic [PHASE_W-1:0] QUARTER = 32'h4000_0000;

  // odd polynomial for sine over a quarter turn, horner order
  localparam logic [30:0] PC9 = 31'd172272;
  localparam logic [30:0] HORNER_C [4] = '{31'd5026995, 31'd85569306,
                                           31'd693598668, 31'd1686629713};

  // 2^28 / (2 pi), radians to turns
  localparam logic signed [26:0] TURN_K = 27'sd42722830;

  typedef struct packed {
    logic signed [COEF_W-1:0] sin_c;
    logic signed [COEF_W-1:0] cos_c;
    logic signed [COEF_W-1:0] sin2_c;
    logic signed [COEF_W-1:0] cos2_c;
  } coef_t;

  typedef struct packed {
    logic [PHASE_W-1:0] ctr;
    logic [LANES-1:0]   mask;
    logic               dom;
  } side_t;

endpackage

/* design/plsu_if.sv */
// plsu_if: valid/ready channels for site requests and updated phases
// depends on plsu_pkg

interface plsu_in_if;
  logic                          valid;
  logic                          ready;
  logic [plsu_pkg::COORD_W-1:0]  row;
  logic [plsu_pkg::COORD_W-1:0]  col;
  logic [plsu_pkg::PHASE_W-1:0]  phase_center;
  logic [plsu_pkg::PHASE_W-1:0]  phase_row_next;
  logic [plsu_pkg::PHASE_W-1:0]  phase_row_prev;
  logic [plsu_pkg::PHASE_W-1:0]  phase_col_next;
  logic [plsu_pkg::PHASE_W-1:0]  phase_col_prev;

  modport source (output valid, row, col, phase_center, phase_row_next,
                  phase_row_prev, phase_col_next, phase_col_prev, input ready);
  modport sink (input valid, row, col, phase_center, phase_row_next,
                phase_row_prev, phase_col_next, phase_col_prev, output ready);
endinterface

interface plsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [plsu_pkg::PHASE_W-1:0]  new_phase;
  logic                          in_domain;

  modport source (output valid, new_phase, in_domain, input ready);
  modport sink (input valid, new_phase, in_domain, output ready);
endinterface

/* design/plsu_sine.sv */
// plsu_sine: pipelined q1.30 sine of a 32-bit turn fraction, 7 stages
// depends on plsu_pkg

module plsu_sine (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [31:0]         angle_i,
  output logic signed [31:0]  sin_o
);

  logic [30:0]        t_q   [6];
  logic               neg_q [6];
  logic [30:0]        t2_q  [4];
  logic [30:0]        p_q   [4];
  logic signed [31:0] sin_q;

  logic [30:0] t_d;
  logic [61:0] sq;
  logic [61:0] fin;
  logic [31:0] mag;

  always_comb begin
    // mirror odd quadrants
    if (angle_i[30]) begin
      t_d = 31'(plsu_pkg::QUARTER) - {1'b0, angle_i[29:0]};
    end else begin
      t_d = {1'b0, angle_i[29:0]};
    end
    sq  = 62'(t_q[0]) * 62'(t_q[0]);
    fin = 62'(p_q[3]) * 62'(t_q[5]);
    mag = fin[61:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0]   <= t_d;
      neg_q[0] <= angle_i[31];
      t2_q[0]  <= sq[60:30];
      t_q[1]   <= t_q[0];
      neg_q[1] <= neg_q[0];
      sin_q    <= neg_q[5] ? -$signed(mag) : $signed(mag);
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_horner
    logic [30:0] pin;
    logic [61:0] prod;
    logic [31:0] pnext;

    always_comb begin
      pin   = (j == 0) ? plsu_pkg::PC9 : p_q[(j == 0) ? 0 : j-1];
      prod  = 62'(pin) * 62'(t2_q[j]);
      pnext = {1'b0, plsu_pkg::HORNER_C[j]} - prod[61:30];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[j]     <= pnext[30:0];
        t_q[j+2]   <= t_q[j+1];
        neg_q[j+2] <= neg_q[j+1];
      end
    end

    if (j < 3) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          t2_q[j+1] <= t2_q[j];
        end
      end
    end
  end

  assign sin_o = sin_q;

endmodule

/* design/plsu_lane.sv */
// plsu_lane: coupling term h(neighbor - center) for one neighbor, 9 stages
// depends on plsu_pkg and plsu_sine

module plsu_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [plsu_pkg::PHASE_W-1:0]         diff_i,
  input  plsu_pkg::coef_t                      coef_i,
  output logic signed [plsu_pkg::LANE_W-1:0]   sum_o
);

  logic [31:0]        angle [4];
  logic signed [31:0] trig  [4];
  logic signed [32:0] cm1;
  logic signed [32:0] c2m1;

  logic signed [plsu_pkg::TERM_W-1:0] term_q [4];
  logic signed [plsu_pkg::LANE_W-1:0] sum_q;

  // sin x, cos x, sin 2x, cos 2x
  assign angle[0] = diff_i;
  assign angle[1] = diff_i + plsu_pkg::QUARTER;
  assign angle[2] = {diff_i[30:0], 1'b0};
  assign angle[3] = {diff_i[30:0], 1'b0} + plsu_pkg::QUARTER;

  for (genvar k = 0; k < 4; k++) begin : g_trig
    plsu_sine u_sine (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .angle_i (angle[k]),
      .sin_o   (trig[k])
    );
  end

  // cos minus one
  assign cm1  = {trig[1][31], trig[1]} - 33'sd1073741824;
  assign c2m1 = {trig[3][31], trig[3]} - 33'sd1073741824;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q[0] <= $signed(coef_i.sin_c)  * trig[0];
      term_q[1] <= $signed(coef_i.sin2_c) * trig[2];
      term_q[2] <= $signed(coef_i.cos_c)  * cm1;
      term_q[3] <= $signed(coef_i.cos2_c) * c2m1;
      sum_q     <= plsu_pkg::LANE_W'(term_q[0]) + plsu_pkg::LANE_W'(term_q[1])
                 + plsu_pkg::LANE_W'(term_q[2]) + plsu_pkg::LANE_W'(term_q[3]);
    end
  end

  assign sum_o = sum_q;

endmodule

/* design/plsu_merge.sv */
// plsu_merge: sums the lanes, scales by dt and 1/(2 pi), adds to the center phase
// depends on plsu_pkg

module plsu_merge (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [plsu_pkg::LANE_W-1:0]  lane_sum_i [plsu_pkg::LANES],
  input  plsu_pkg::side_t                     side_i,
  input  logic [plsu_pkg::COEF_W-1:0]         step_i,
  output logic [plsu_pkg::PHASE_W-1:0]        new_phase_o,
  output logic                                in_domain_o
);

  logic signed [plsu_pkg::TOTAL_W-1:0] total_d, total_q;
  logic signed [54:0] sdt;
  logic signed [38:0] m_q;
  logic signed [45:0] ph_q;
  logic signed [47:0] pl_q;
  logic signed [65:0] full;
  plsu_pkg::side_t    side_q [3];
  logic [plsu_pkg::PHASE_W-1:0] phase_q;
  logic                         dom_q;

  always_comb begin
    total_d = '0;
    for (int k = 0; k < plsu_pkg::LANES; k++) begin
      if (side_i.mask[k]) begin
        total_d = total_d + plsu_pkg::TOTAL_W'(lane_sum_i[k]);
      end
    end
    // floor by 2^14 then times dt
    sdt  = $signed(total_q[plsu_pkg::TOTAL_W-1:14]) * $signed({1'b0, step_i});
    full = ($signed(66'(ph_q)) <<< 20) + 66'(pl_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      total_q   <= total_d;
      side_q[0] <= side_i;
      m_q       <= sdt[54:16];
      side_q[1] <= side_q[0];
      // split m so each product stays narrow
      ph_q      <= $signed(m_q[38:20]) * plsu_pkg::TURN_K;
      pl_q      <= $signed({1'b0, m_q[19:0]}) * plsu_pkg::TURN_K;
      side_q[2] <= side_q[1];
      phase_q   <= side_q[2].dom ? side_q[2].ctr + full[57:26] : side_q[2].ctr;
      dom_q     <= side_q[2].dom;
    end
  end

  assign new_phase_o = phase_q;
  assign in_domain_o = dom_q;

endmodule

/* design/phase_lattice_site_update_top.sv */
// phase_lattice_site_update_top: euler step of one site of an annular phase lattice
// throughput one request per cycle while no finished result is held at the output
// the four neighbor lanes each hold four 7-stage sine pipelines
// the whole pipe stalls only while a finished result waits at the output
// async active-low reset clears the valid pipe and loads register defaults
// depends on plsu_pkg, plsu_if, plsu_sine, plsu_lane, plsu_merge

module phase_lattice_site_update_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  plsu_in_if.sink                           in_i,
  plsu_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [plsu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [plsu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int LAT = 14;
  localparam int DLY = 7;

  // configuration registers
  logic [plsu_pkg::HS_W-1:0]    half_size_q;
  logic [plsu_pkg::INNER_W-1:0] inner_q;
  logic [19:0]                  hs_sq_q;
  plsu_pkg::coef_t              coef_q;
  logic [plsu_pkg::COEF_W-1:0]  step_q;
  logic [plsu_pkg::HS_W-1:0]    hs_sat;

  // oversized radius saturates to the supported maximum
  assign hs_sat = ({3'b0, cfg_data_i[plsu_pkg::HS_W-1:0]} > 13'(plsu_pkg::MAX_HALF_SIZE))
                ? plsu_pkg::HS_W'(plsu_pkg::MAX_HALF_SIZE) : cfg_data_i[plsu_pkg::HS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_size_q   <= plsu_pkg::RST_HALF_SIZE;
      inner_q       <= plsu_pkg::RST_INNER_R2;
      coef_q.sin_c  <= plsu_pkg::RST_SIN_COEF;
      coef_q.cos_c  <= plsu_pkg::RST_COS_COEF;
      coef_q.sin2_c <= plsu_pkg::RST_SIN2_COEF;
      coef_q.cos2_c <= plsu_pkg::RST_COS2_COEF;
      step_q        <= plsu_pkg::RST_STEP_SIZE;
      hs_sq_q       <= 20'd40000;
    end else begin
      // outer radius squared, registered from the half size register
      hs_sq_q <= 20'(half_size_q) * 20'(half_size_q);
      if (cfg_we_i) begin
        case (plsu_pkg::cfg_idx_e'(cfg_idx_i))
          plsu_pkg::CFG_HALF_SIZE: half_size_q   <= hs_sat;
          plsu_pkg::CFG_INNER_R2:  inner_q       <= cfg_data_i;
          plsu_pkg::CFG_SIN_COEF:  coef_q.sin_c  <= cfg_data_i[15:0];
          plsu_pkg::CFG_COS_COEF:  coef_q.cos_c  <= cfg_data_i[15:0];
          plsu_pkg::CFG_SIN2_COEF: coef_q.sin2_c <= cfg_data_i[15:0];
          plsu_pkg::CFG_COS2_COEF: coef_q.cos2_c <= cfg_data_i[15:0];
          plsu_pkg::CFG_STEP_SIZE: step_q        <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // pipeline control: everything advances together unless the output is held
  logic           en;
  logic           fire;
  logic [LAT-1:0] vld_q;

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;
  assign fire       = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], fire};
    end
  end

  // stage 1: neighbor differences and offsets from the grid center
  logic [plsu_pkg::PHASE_W-1:0] ctr1_q;
  logic [plsu_pkg::PHASE_W-1:0] diff_q [plsu_pkg::LANES];
  logic signed [12:0]           dr_q, dc_q;
  logic [12:0]                  cpos;

  assign cpos = 13'(half_size_q) + 13'd1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctr1_q    <= in_i.phase_center;
      diff_q[0] <= in_i.phase_row_next - in_i.phase_center;
      diff_q[1] <= in_i.phase_row_prev - in_i.phase_center;
      diff_q[2] <= in_i.phase_col_next - in_i.phase_center;
      diff_q[3] <= in_i.phase_col_prev - in_i.phase_center;
      dr_q      <= $signed(13'(in_i.row) - cpos);
      dc_q      <= $signed(13'(in_i.col) - cpos);
    end
  end

  // stage 2: squared offsets for the site and the row/column moved by one
  logic signed [12:0] drs [3];
  logic signed [12:0] dcs [3];
  logic signed [25:0] rsq [3];
  logic signed [25:0] csq [3];
  logic [22:0]        sqr_q [3];
  logic [22:0]        sqc_q [3];
  logic [plsu_pkg::PHASE_W-1:0] ctr2_q;

  always_comb begin
    drs[0] = dr_q;
    drs[1] = dr_q + 13'sd1;
    drs[2] = dr_q - 13'sd1;
    dcs[0] = dc_q;
    dcs[1] = dc_q + 13'sd1;
    dcs[2] = dc_q - 13'sd1;
    for (int k = 0; k < 3; k++) begin
      rsq[k] = drs[k] * drs[k];
      csq[k] = dcs[k] * dcs[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sqr_q[k] <= rsq[k][22:0];
        sqc_q[k] <= csq[k][22:0];
      end
      ctr2_q <= ctr1_q;
    end
  end

  // stage 3: annulus tests; sites off the grid always fail the outer bound
  function automatic logic in_ann(input logic [22:0] a, input logic [22:0] b,
                                  input logic [plsu_pkg::INNER_W-1:0] inner,
                                  input logic [19:0] nsq);
    logic [23:0] r2;
    r2 = 24'(a) + 24'(b);
    return (r2 >= 24'(inner)) && (r2 <= 24'(nsq));
  endfunction

  plsu_pkg::side_t side_d;
  plsu_pkg::side_t side3_q;
  plsu_pkg::side_t dly_q [DLY];

  always_comb begin
    side_d.ctr     = ctr2_q;
    side_d.dom     = in_ann(sqr_q[0], sqc_q[0], inner_q, hs_sq_q);
    // lanes: row next, row prev, col next, col prev
    side_d.mask[0] = side_d.dom && in_ann(sqr_q[1], sqc_q[0], inner_q, hs_sq_q);
    side_d.mask[1] = side_d.dom && in_ann(sqr_q[2], sqc_q[0], inner_q, hs_sq_q);
    side_d.mask[2] = side_d.dom && in_ann(sqr_q[0], sqc_q[1], inner_q, hs_sq_q);
    side_d.mask[3] = side_d.dom && in_ann(sqr_q[0], sqc_q[2], inner_q, hs_sq_q);
  end

  // delay line lines the side info up with the lane results
  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q  <= side_d;
      dly_q[0] <= side3_q;
      for (int k = 1; k < DLY; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  // neighbor lanes
  logic signed [plsu_pkg::LANE_W-1:0] lane_sum [plsu_pkg::LANES];

  for (genvar k = 0; k < plsu_pkg::LANES; k++) begin : g_lane
    plsu_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .diff_i (diff_q[k]),
      .coef_i (coef_q),
      .sum_o  (lane_sum[k])
    );
  end

  // merge and output register
  plsu_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en),
    .lane_sum_i  (lane_sum),
    .side_i      (dly_q[DLY-1]),
    .step_i      (step_q),
    .new_phase_o (out_o.new_phase),
    .in_domain_o (out_o.in_domain)
  );

  assign out_o.valid = vld_q[LAT-1];

  // an accepted request enters the valid pipe
  a_fire_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted request lost at pipe entry");

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("request taken while output stalled");

  // a result appears only from the stage before it
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(vld_q[LAT-2]))
    else $error("result without a request behind it");

endmodule

/* tb/tb_plsu_if.sv */
// testbench copies of nothing: the channel interfaces come from the design
// this file holds the small helper package for the lattice site testbench
// depends on plsu_pkg
`timescale 1ns / 100ps

package tb_plsu_pkg;
  import plsu_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PHASE_W-1:0] ctr;
    logic [PHASE_W-1:0] rn;
    logic [PHASE_W-1:0] rp;
    logic [PHASE_W-1:0] cn;
    logic [PHASE_W-1:0] cp;
  } site_req_t;

  typedef struct packed {
    logic [PHASE_W-1:0] new_phase;
    logic               in_domain;
  } site_res_t;
endpackage

/* tb/tb.sv */
// tb: self-checking bench for phase_lattice_site_update_top
// drives site requests through valid/ready, predicts each updated phase in
// fixed point and compares in order; depends on plsu_pkg, plsu_if, tb_plsu_pkg
`timescale 1ns / 100ps

module tb;
  import plsu_pkg::*;
  import tb_plsu_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  plsu_in_if  in_ch ();
  plsu_out_if out_ch ();

  phase_lattice_site_update_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // model copy of the register file
  longint hs_m, inner_m, dt_m;
  longint a1_m, b1_m, a2_m, b2_m;

  site_req_t pending_sites[$];
  site_res_t expected_phases[$];
  int        errors = 0;
  int        send_idle_pct = 0;  // sender gap chance, percent
  int        recv_stall_pct = 0; // receiver stall chance, percent

  initial forever #5 clk_i = ~clk_i;

  // generous ceiling, the slowest correct run is far below this
  initial begin
    #50ms;
    $display("** phase_lattice_site_update_top: FAILED **");
    $finish;
  end

  function automatic longint sext16(longint v);
    v = v & 'hFFFF;
    return (v >= 'h8000) ? v - 65536 : v;
  endfunction

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;  // arithmetic shift floors toward minus infinity
  endfunction

  // quarter-wave polynomial sine, q1.30
  function automatic longint quarter_sin(longint t);
    longint t2, p;
    t2 = (t * t) >> 30;
    p = 172272;
    p = 5026995 - ((p * t2) >> 30);
    p = 85569306 - ((p * t2) >> 30);
    p = 693598668 - ((p * t2) >> 30);
    p = 1686629713 - ((p * t2) >> 30);
    return (p * t) >> 30;
  endfunction

  function automatic longint sin30(logic [31:0] a);
    longint f, s;
    f = longint'(a[29:0]);
    s = quarter_sin(a[30] ? (longint'(1) << 30) - f : f);
    return a[31] ? -s : s;
  endfunction

  function automatic longint cos30(logic [31:0] a);
    return sin30(a + 32'h4000_0000);
  endfunction

  function automatic longint pair_coupling(logic [31:0] nb, logic [31:0] c);
    logic [31:0] d, d2;
    longint one;
    d = nb - c;
    d2 = d << 1;
    one = longint'(1) << 30;
    return a1_m * sin30(d) + a2_m * sin30(d2) + b1_m * (cos30(d) - one)
         + b2_m * (cos30(d2) - one);
  endfunction

  function automatic bit in_ring(longint r, longint c);
    longint dr, dc, r2;
    dr = r - (hs_m + 1);
    dc = c - (hs_m + 1);
    r2 = dr * dr + dc * dc;
    return r2 <= hs_m * hs_m && r2 >= inner_m;
  endfunction

  function automatic site_res_t predict_site(site_req_t q);
    site_res_t res;
    longint r, c, last, sum, s, m, dl;
    r = q.row;
    c = q.col;
    last = 2 * hs_m + 1;
    sum = 0;
    if (!in_ring(r, c)) begin
      res.new_phase = q.ctr;
      res.in_domain = 1'b0;
      return res;
    end
    if (r + 1 <= last && in_ring(r + 1, c)) sum += pair_coupling(q.rn, q.ctr);
    if (r - 1 >= 1 && in_ring(r - 1, c)) sum += pair_coupling(q.rp, q.ctr);
    if (c + 1 <= last && in_ring(r, c + 1)) sum += pair_coupling(q.cn, q.ctr);
    if (c - 1 >= 1 && in_ring(r, c - 1)) sum += pair_coupling(q.cp, q.ctr);
    s = floor_sh(sum, 14);
    m = floor_sh(s * dt_m, 16);
    dl = floor_sh(m * 42722830, 26);
    res.new_phase = q.ctr + dl[31:0];
    res.in_domain = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // driver: one request per handshake, random gaps by phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.row <= '0;
      in_ch.col <= '0;
      in_ch.phase_center <= '0;
      in_ch.phase_row_next <= '0;
      in_ch.phase_row_prev <= '0;
      in_ch.phase_col_next <= '0;
      in_ch.phase_col_prev <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_phases.push_back(predict_site({in_ch.row, in_ch.col,
          in_ch.phase_center, in_ch.phase_row_next, in_ch.phase_row_prev,
          in_ch.phase_col_next, in_ch.phase_col_prev}));
      if (pending_sites.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        site_req_t q;
        q = pending_sites.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.row <= q.row;
        in_ch.col <= q.col;
        in_ch.phase_center <= q.ctr;
        in_ch.phase_row_next <= q.rn;
        in_ch.phase_row_prev <= q.rp;
        in_ch.phase_col_next <= q.cn;
        in_ch.phase_col_prev <= q.cp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_phases.size() == 0) begin
          report_mismatch("unexpected result", out_ch.new_phase, 0);
        end else begin
          site_res_t w;
          w = expected_phases.pop_front();
          if (out_ch.new_phase !== w.new_phase)
            report_mismatch("new_phase", out_ch.new_phase, w.new_phase);
          if (out_ch.in_domain !== w.in_domain)
            report_mismatch("in_domain", out_ch.in_domain, w.in_domain);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HALF_SIZE: begin
        hs_m = val & 'h3FF;
        if (hs_m > MAX_HALF_SIZE) hs_m = MAX_HALF_SIZE;
      end
      CFG_INNER_R2:  inner_m = val & 'h7FFFF;
      CFG_SIN_COEF:  a1_m = sext16(val);
      CFG_COS_COEF:  b1_m = sext16(val);
      CFG_SIN2_COEF: a2_m = sext16(val);
      CFG_COS2_COEF: b2_m = sext16(val);
      CFG_STEP_SIZE: dt_m = val & 'hFFFF;
      default: ;
    endcase
  endtask

  task automatic load_regs(longint hs, longint ir, longint a1, longint b1,
                           longint a2, longint b2, longint dt);
    write_reg(CFG_HALF_SIZE, hs);
    write_reg(CFG_INNER_R2, ir);
    write_reg(CFG_SIN_COEF, a1);
    write_reg(CFG_COS_COEF, b1);
    write_reg(CFG_SIN2_COEF, a2);
    write_reg(CFG_COS2_COEF, b2);
    write_reg(CFG_STEP_SIZE, dt);
  endtask

  function automatic site_req_t rand_site(bit mostly_inside);
    site_req_t q;
    longint span;
    span = 2 * hs_m + 1;
    if (mostly_inside && $urandom_range(9) != 0) begin
      q.row = COORD_W'($urandom_range(span, 1));
      q.col = COORD_W'($urandom_range(span, 1));
    end else begin
      q.row = COORD_W'($urandom);
      q.col = COORD_W'($urandom);
    end
    q.ctr = $urandom;
    // some neighbors often close to the center, the rest anywhere
    q.rn = ($urandom_range(1)) ? $urandom : q.ctr + $urandom_range(65535) - 32768;
    q.rp = ($urandom_range(1)) ? $urandom : q.ctr + ($urandom << 4);
    q.cn = $urandom;
    q.cp = ($urandom_range(3) == 0) ? q.ctr : $urandom;
    return q;
  endfunction

  function automatic site_req_t fixed_site(longint r, longint c, logic [31:0] ctr,
                                           logic [31:0] nb);
    site_req_t q;
    q.row = COORD_W'(r);
    q.col = COORD_W'(c);
    q.ctr = ctr;
    q.rn = nb;
    q.rp = ~nb;
    q.cn = nb + 32'h4000_0000;
    q.cp = nb ^ 32'h8000_0000;
    return q;
  endfunction

  // wait for every request to be accepted and every result to drain
  task automatic drain_all();
    int n;
    n = 0;
    while (pending_sites.size() > 0 || in_ch.valid || expected_phases.size() > 0)
      @(posedge clk_i);
    while (n < 20) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) pending_sites.push_back(rand_site(1'b1));
    drain_all();
  endtask

  initial begin
    hs_m = RST_HALF_SIZE;
    inner_m = RST_INNER_R2;
    a1_m = sext16(RST_SIN_COEF);
    b1_m = sext16(RST_COS_COEF);
    a2_m = sext16(RST_SIN2_COEF);
    b2_m = sext16(RST_COS2_COEF);
    dt_m = RST_STEP_SIZE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, center, edges, corners, out of grid, extremes
    pending_sites.push_back(fixed_site(201, 201, 32'h0, 32'h1000_0000));
    pending_sites.push_back(fixed_site(1, 201, 32'hFFFF_FFFF, 32'h0));
    pending_sites.push_back(fixed_site(401, 201, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_sites.push_back(fixed_site(201, 1, 32'h1234_5678, 32'h4000_0000));
    pending_sites.push_back(fixed_site(201, 401, 32'hC000_0000, 32'h3FFF_FFFF));
    pending_sites.push_back(fixed_site(1, 1, 32'h0, 32'h8000_0000));
    pending_sites.push_back(fixed_site(0, 0, 32'hDEAD_BEEF, 32'h0));
    pending_sites.push_back(fixed_site(2047, 2047, 32'h5555_5555, 32'hAAAA_AAAA));
    pending_sites.push_back(fixed_site(1025, 1025, 32'h0, 32'hFFFF_FFFF));
    drain_all();

    // extremes: largest grid, saturating half size, max coefficients
    load_regs(1023, 0, 32767, -32768, 32767, -32768, 65535);
    pending_sites.push_back(fixed_site(513, 513, 32'h0, 32'h2000_0000));
    pending_sites.push_back(fixed_site(1, 513, 32'hFFFF_FFFF, 32'hE000_0000));
    pending_sites.push_back(fixed_site(1025, 513, 32'h0, 32'h7FFF_FFFF));
    pending_sites.push_back(fixed_site(513, 1025, 32'h8000_0000, 32'h0));
    pending_sites.push_back(fixed_site(2047, 1, 32'h0, 32'h0));
    drain_all();
    // zero half size: only the lone center site counts
    load_regs(0, 0, -32768, 32767, -32768, 32767, 0);
    pending_sites.push_back(fixed_site(1, 1, 32'h1111_1111, 32'h0));
    pending_sites.push_back(fixed_site(2, 1, 32'h1111_1111, 32'h0));
    pending_sites.push_back(fixed_site(0, 0, 32'h1111_1111, 32'h0));
    drain_all();
    // small annulus with a hole, sites next to the inner edge
    load_regs(6, 9, 20000, -12000, -7000, 9000, 40000);
    pending_sites.push_back(fixed_site(7, 7, 32'h0, 32'h1));
    pending_sites.push_back(fixed_site(7, 10, 32'h0, 32'h4000_0000));
    pending_sites.push_back(fixed_site(7, 11, 32'hFFFF_0000, 32'h0));
    pending_sites.push_back(fixed_site(1, 7, 32'h0, 32'h8000_0001));
    pending_sites.push_back(fixed_site(13, 13, 32'h0, 32'h0));
    drain_all();
    load_regs(512, 262143, 1, -1, 2, -2, 1);
    pending_sites.push_back(fixed_site(1, 1, 32'h0, 32'h8000_0000));
    pending_sites.push_back(fixed_site(513, 1, 32'h0, 32'h8000_0000));
    drain_all();

    // random phases over several settings and idling patterns
    load_regs(8, 4, 16384, 6554, 0, 0, 13107);
    random_phase(110, 0, 0);
    load_regs(20, 30, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(110, 52, 0);
    load_regs(3, 0, -32768, -32768, 32767, 32767, 65535);
    random_phase(110, 0, 52);
    load_regs(512, 70000, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(110, 10, 10);
    load_regs(1, 0, 32767, 32767, -32768, -32768, 65535);
    random_phase(60, 52, 52);
    load_regs(15, 50, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(150, 0, 0);

    if (errors == 0) begin
      $display("** phase_lattice_site_update_top: PASSED **");
    end else begin
      $display("** phase_lattice_site_update_top: FAILED **");
    end
    $finish;
  end
endmodule
